>>> rtl/core/mffu_pkg.sv
// Shared types, constants and helpers for the motor feedback filter.
// No dependencies.
package mffu_pkg;

    localparam int unsigned FilterChannels = 8;
    localparam int unsigned EncoderCounts  = 8192;

    localparam logic [10:0] ID_DRIVE_FIRST = 11'h201;
    localparam logic [10:0] ID_DRIVE_LAST  = 11'h204;
    localparam logic [10:0] ID_YAW         = 11'h20B;
    localparam logic [10:0] ID_FEEDER      = 11'h206;

    localparam logic [2:0] SLOT_YAW    = 3'd4;
    localparam logic [2:0] SLOT_FEEDER = 3'd6;

    localparam logic [23:0] VAR_RESET = 24'd25600;

    localparam logic [1:0] CFG_DECIM  = 2'd0;
    localparam logic [1:0] CFG_PNOISE = 2'd1;
    localparam logic [1:0] CFG_MNOISE = 2'd2;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic load;       // capture input frame
        logic kf_start;   // begin one filter step on sel channel
        logic kf_delta;   // 1: angle step channel, 0: speed channel
        logic unwrap;     // run angle load, unwrap and jump test
        logic finish;     // assemble the result
    } mffu_cmd_t;

    typedef struct packed {
        logic drive;      // frame is a drive motor
        logic known;      // frame id matched
        logic upd;        // angle update is due
        logic kf_done;    // filter step finished
    } mffu_sts_t;

    typedef struct packed {
        logic        matched;
        logic [2:0]  motor_slot;
        logic [15:0] speed_out;
        logic [15:0] angle_out;
        logic [15:0] delta_out;
        logic [15:0] current_out;
        logic        angle_updated;
    } mffu_res_t;

    // Integer part of a Q16.8 estimate, rounded toward zero, saturated
    function automatic logic signed [15:0] est_int(input logic signed [24:0] e);
        logic signed [24:0] q;
        begin
            q = (e < 0) ? -((-e) >>> 8) : (e >>> 8);
            if (q > 25'sd32767)       est_int = 16'sh7FFF;
            else if (q < -25'sd32768) est_int = 16'sh8000;
            else                      est_int = q[15:0];
        end
    endfunction

endpackage

>>> rtl/core/mffu_kalman.sv
// Iterative scalar Kalman step: restoring divider for the gain, then
// registered multiplies. Depends on mffu_pkg.
module mffu_kalman
    import mffu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] meas,
    input  logic signed [24:0] est_in,
    input  logic [23:0]        var_in,
    input  logic [15:0]        process_noise,
    input  logic [15:0]        measure_noise,
    output logic               done,
    output logic signed [24:0] est_out,
    output logic [23:0]        var_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRED = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic [24:0]        vp_reg;
    logic [25:0]        den_reg;
    logic [41:0]        num_reg;
    logic [26:0]        rem_reg;
    logic [16:0]        quo_reg;
    logic [15:0]        k_reg;
    logic signed [33:0] diff_reg;
    logic signed [51:0] p_reg;
    logic [40:0]        vm_reg;

    logic [24:0]        vp_sum;
    logic [26:0]        rem_shift;
    logic signed [51:0] corr;
    logic signed [34:0] e_sum;

    assign vp_sum    = {1'b0, var_in} + {1'b0, process_noise, 8'd0};
    assign rem_shift = {rem_reg[25:0], num_reg[41]};
    assign corr      = p_reg >>> 16;
    assign e_sum     = 35'(est_in) + 35'(corr);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start) state_next = ST_PRED;
            ST_PRED: state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 5'd0) state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                vp_reg <= (vp_sum > 25'hFFFFFF) ? 25'hFFFFFF : vp_sum;
            end
            ST_PRED: begin
                // quotient fits in 17 bits as VP never exceeds the denominator,
                // so start the remainder from the top bits of VP*65536
                den_reg  <= {1'b0, vp_reg} + {2'b0, measure_noise, 8'd0};
                num_reg  <= {vp_reg[0], 41'd0};
                rem_reg  <= 27'(vp_reg[24:1]);
                quo_reg  <= '0;
                cnt_reg  <= 5'd16;
                diff_reg <= 34'(meas) * 34'sd256 - 34'(est_in);
            end
            ST_DIV: begin
                // one quotient bit a cycle over the low 17 bits
                num_reg <= {num_reg[40:0], 1'b0};
                if (rem_shift >= {1'b0, den_reg}) begin
                    rem_reg <= rem_shift - {1'b0, den_reg};
                    quo_reg <= {quo_reg[15:0], 1'b1};
                end else begin
                    rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[15:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            ST_MUL: begin
                k_reg <= (den_reg == '0 || quo_reg[16]) ? 16'hFFFF : quo_reg[15:0];
            end
            ST_UPD: begin
                p_reg  <= 52'($signed({1'b0, k_reg})) * 52'(diff_reg) + 52'sd32768;
                vm_reg <= 41'({1'b0, 17'h10000 - {1'b0, k_reg}}) * 41'(vp_reg[23:0]);
            end
            default: ;
        endcase
    end

    // Estimate and variance are valid in the DONE cycle only
    assign done    = (state_reg == ST_DONE);
    assign est_out = e_sum > 35'sd16777215 ? 25'sh0FFFFFF :
                     e_sum < -35'sd16777216 ? 25'sh1000000 : e_sum[24:0];
    assign var_out = vm_reg[39:16];

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("kalman done held");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PRED) |=> (cnt_reg == 5'd16)) else $error("divider count");
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && state_reg != ST_IDLE) |-> 1'b0) else $error("start while busy");
`endif

endmodule

>>> rtl/core/mffu_datapath.sv
// Frame registers, filter and angle state, unwrap logic and result register.
// Depends on mffu_pkg and mffu_kalman.
module mffu_datapath
    import mffu_pkg::*;
#(
    parameter int unsigned ENCODER_COUNTS = EncoderCounts
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  mffu_cmd_t   cmd,
    output mffu_sts_t   sts,
    input  logic [58:0] frame,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output mffu_res_t   res
);

    localparam logic signed [15:0] Enc = 16'(ENCODER_COUNTS);

    logic [7:0]  decim_reg;
    logic [15:0] pnoise_reg, mnoise_reg;
    logic [58:0] frame_reg;

    logic signed [24:0] est_reg [FilterChannels];
    logic [23:0]        var_reg [FilterChannels];
    logic [7:0]         fcnt_reg [4];
    logic [15:0]        ang_reg [7];
    logic signed [15:0] acc_reg [4];

    logic signed [15:0] s_reg, d_reg;
    logic               upd_reg;

    logic [10:0]        id;
    logic [15:0]        ang, spd, cur;
    logic               drive;
    logic [1:0]         m;
    logic [2:0]         ch;
    logic               kdone;
    logic signed [24:0] kest;
    logic [23:0]        kvar;
    logic [7:0]         fcnt_inc;
    mffu_res_t          res_next;

    assign id    = frame_reg[10:0];
    assign ang   = frame_reg[26:11];
    assign spd   = frame_reg[42:27];
    assign cur   = frame_reg[58:43];
    assign drive = (id >= ID_DRIVE_FIRST) && (id <= ID_DRIVE_LAST);
    assign m     = 2'(id - ID_DRIVE_FIRST);
    assign ch    = {~cmd.kf_delta, m};
    assign fcnt_inc = fcnt_reg[m] + 8'd1;

    mffu_kalman u_kalman (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (cmd.kf_start),
        .meas          (cmd.kf_delta ? d_reg : spd),
        .est_in        (est_reg[ch]),
        .var_in        (var_reg[ch]),
        .process_noise (pnoise_reg),
        .measure_noise (mnoise_reg),
        .done          (kdone),
        .est_out       (kest),
        .var_out       (kvar)
    );

    assign sts.drive   = drive;
    assign sts.known   = drive || id == ID_YAW || id == ID_FEEDER;
    assign sts.upd     = upd_reg;
    assign sts.kf_done = kdone;

    always_ff @(posedge aclk) begin
        if (cmd.load) frame_reg <= frame;
    end

    // Unwrap chain for one drive motor
    logic signed [15:0] d0, d1, d2, sz;
    logic signed [16:0] jump;
    always_comb begin
        sz = (s_reg < 16'sd5 && s_reg > -16'sd5) ? 16'sd0 : s_reg;
        d0 = $signed(ang) - $signed(ang_reg[{1'b0, m}]);
        if (sz >= 0 && d0 < -16'sd10)     d1 = d0 + Enc;
        else if (sz < 0 && d0 > 16'sd10)  d1 = d0 - Enc;
        else                              d1 = d0;
        jump = 17'(d1) - 17'(acc_reg[m]);
        if (jump > 17'sd4000)       d2 = d1 - Enc;
        else if (jump < -17'sd4000) d2 = d1 + Enc;
        else                        d2 = d1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decim_reg  <= 8'd1;
            pnoise_reg <= 16'd600;
            mnoise_reg <= 16'd5000;
            upd_reg    <= 1'b0;
            for (int i = 0; i < FilterChannels; i++) begin
                est_reg[i] <= '0;
                var_reg[i] <= VAR_RESET;
            end
            for (int i = 0; i < 4; i++) begin
                fcnt_reg[i] <= '0;
                acc_reg[i]  <= '0;
            end
            for (int i = 0; i < 7; i++) ang_reg[i] <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_DECIM:  decim_reg  <= cfg_data[7:0];
                    CFG_PNOISE: pnoise_reg <= cfg_data;
                    CFG_MNOISE: mnoise_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load) upd_reg <= 1'b0;
            if (kdone) begin
                est_reg[ch] <= kest;
                var_reg[ch] <= kvar;
                if (!cmd.kf_delta) begin
                    s_reg <= est_int(kest);
                    if (fcnt_inc == decim_reg) begin
                        fcnt_reg[m] <= '0;
                        upd_reg     <= 1'b1;
                    end else begin
                        fcnt_reg[m] <= fcnt_inc;
                    end
                end
            end
            if (cmd.unwrap) begin
                ang_reg[{1'b0, m}] <= ang;
                s_reg      <= sz;
                d_reg      <= d2;
                if (jump <= 17'sd4000 && jump >= -17'sd4000) acc_reg[m] <= d1;
            end
            if (cmd.finish && !drive) begin
                if (id == ID_YAW)    ang_reg[SLOT_YAW]    <= ang;
                if (id == ID_FEEDER) ang_reg[SLOT_FEEDER] <= ang;
            end
        end
    end

    always_comb begin
        res_next = '0;
        if (drive) begin
            res_next.matched       = 1'b1;
            res_next.motor_slot    = {1'b0, m};
            res_next.speed_out     = s_reg;
            res_next.angle_out     = ang_reg[{1'b0, m}];
            res_next.delta_out     = est_int(est_reg[{1'b0, m}]);
            res_next.angle_updated = upd_reg;
        end else if (id == ID_YAW || id == ID_FEEDER) begin
            res_next.matched     = 1'b1;
            res_next.motor_slot  = (id == ID_YAW) ? SLOT_YAW : SLOT_FEEDER;
            res_next.speed_out   = spd;
            res_next.angle_out   = ang;
            res_next.current_out = cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) res <= res_next;
    end

endmodule

>>> rtl/core/mffu_ctrl.sv
// Sequencer for one frame: speed filter, optional unwrap and step filter for a drive motor,
// then the result. Depends on mffu_pkg.
module mffu_ctrl
    import mffu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  mffu_sts_t sts,
    output mffu_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DEC    = 3'd1;
    localparam logic [2:0] ST_KSPD   = 3'd2;
    localparam logic [2:0] ST_UNWRAP = 3'd3;
    localparam logic [2:0] ST_KDLT   = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       started_reg, started_next;
    logic       hold_reg, hold_next;

    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_OUT && out_ready);
    assign out_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        hold_next    = hold_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE, ST_OUT: begin
                if (state_reg == ST_OUT && out_ready) state_next = ST_IDLE;
                if (in_valid && in_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next   = sts.drive ? ST_KSPD : ST_FIN;
                started_next = 1'b0;
            end
            ST_KSPD: begin
                cmd.kf_start = !started_reg;
                started_next = 1'b1;
                if (sts.kf_done) begin
                    started_next = 1'b0;
                    state_next   = ST_UNWRAP;
                end
            end
            ST_UNWRAP: begin
                // the counter result is visible here
                if (sts.upd) begin
                    cmd.unwrap = 1'b1;
                    state_next = ST_KDLT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_KDLT: begin
                cmd.kf_delta = 1'b1;
                cmd.kf_start = !started_reg;
                started_next = 1'b1;
                if (sts.kf_done) begin
                    started_next = 1'b0;
                    state_next   = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
        hold_next = (state_next == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
            hold_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            hold_reg    <= hold_next;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_hold_track: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_reg == out_valid) else $error("hold flag mismatch");
    a_fin_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> out_valid) else $error("finish without result");
`endif

endmodule

>>> rtl/core/motor_feedback_filter_unwrap.sv
// Motor feedback filter with encoder angle unwrap: top level.
// Depends on mffu_pkg, mffu_ctrl, mffu_datapath.
//
// Usage: one request on the s_ channel carries a received feedback frame;
// one result leaves on the m_ channel for every frame, also for an unknown
// identifier (all fields zero). Drive motor speeds go through a scalar
// Kalman step; on an angle update frame the angle step is unwrapped and
// filtered by a second step.
// Non-drive frames go straight to the result; drive frames run the speed
// Kalman step, on an angle update also the unwrap and the angle step. Each
// step uses a 17-iteration restoring divider. One frame is processed at a
// time; the next is taken in the cycle its result leaves. While the
// receiver stalls the result is held and s_tready stays low. Reset sets
// estimates, variances, counters and angles to initial values and the
// registers to 1, 600 and 5000; no clearing pass. Configuration: cfg_we
// with cfg_index 0..2 must be written only while idle; it is not checked.
module motor_feedback_filter_unwrap
    import mffu_pkg::*;
#(
    parameter int unsigned ENCODER_COUNTS = EncoderCounts
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // frame_id, byte0..byte5 (low bit up)
    output logic        m_tvalid,
    input  logic        m_tready,
    // matched, motor_slot, speed_out, angle_out, delta_out, current_out,
    // angle_updated (low bit up)
    output logic [71:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mffu_cmd_t   cmd;
    mffu_sts_t   sts;
    mffu_res_t   res;
    logic [58:0] frame;

    // byte0/1 angle, byte2/3 speed, byte4/5 current, high byte first
    assign frame = {s_tdata[50:43], s_tdata[58:51],
                    s_tdata[34:27], s_tdata[42:35],
                    s_tdata[18:11], s_tdata[26:19],
                    s_tdata[10:0]};

    mffu_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mffu_datapath #(
        .ENCODER_COUNTS (ENCODER_COUNTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .frame     (frame),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    assign m_tdata = {3'b0, res.angle_updated, res.current_out, res.delta_out,
                      res.angle_out, res.speed_out, res.motor_slot, res.matched};

endmodule
